FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock edge, held off while reset is low.
`define GPBB_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// Assert a property on the rising clock edge with no reset qualifier.
`define GPBB_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

FILE: design/gpbb_pkg.sv
// ----------------------------------------------------------------------------
// gpbb_pkg
// Types, codes and widths for the grade position bang-bang controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gpbb_pkg;

    // Sensor sample bits actually used
    localparam int SAMPLE_BITS = 12;

    // Field and register widths
    localparam int FUNC_W   = 2;
    localparam int SAMPLE_W = 12;
    localparam int GRADE_W  = 7;
    localparam int STEP_W   = 11;
    localparam int HALF_W   = STEP_W - 1;
    localparam int PROD_W   = STEP_W + GRADE_W;
    localparam int CMP_W    = PROD_W + 1;
    localparam int CFG_W    = STEP_W;

    // Beat layout of the input stream
    localparam int IN_FUNC_LSB   = 0;
    localparam int IN_SAMPLE_LSB = IN_FUNC_LSB + FUNC_W;
    localparam int IN_GRADE_LSB  = IN_SAMPLE_LSB + SAMPLE_W;
    localparam int IN_DATA_W     = 24;

    // Beat layout of the result stream
    localparam int OUT_DATA_W = 16;

    // Reset values
    localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(200);
    localparam logic [GRADE_W-1:0] MAX_RESET  = GRADE_W'(16);
    localparam logic [GRADE_W-1:0] GOAL_RESET = GRADE_W'(1);

    // Configuration register indexes
    localparam logic CFG_GRADE_STEP = 1'b0;
    localparam logic CFG_MAX_GRADE  = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_POLL = 2'd0,
        FUNC_UP   = 2'd1,
        FUNC_DOWN = 2'd2,
        FUNC_SET  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        MOTION_NONE = 2'd0,
        MOTION_UP   = 2'd1,
        MOTION_DOWN = 2'd2
    } motion_t;

endpackage

FILE: design/grade_position_bang_bang.sv
// ----------------------------------------------------------------------------
// grade_position_bang_bang
// Bang-bang position controller for a two-relay actuator with a deadband.
// ----------------------------------------------------------------------------
// Takes one beat per clock while the result side is not stalled, and returns
// one result beat for each. The result beat passes through the input
// register, then the result register. While a result waits, the input
// register holds one more beat and s_tready drops. The grade, settled and
// motion state close their loop through an 11x7 multiply of grade step by
// goal grade and the threshold compares that follow it; that path sets the
// clock, not the throughput. Configuration writes go straight into the step
// and max registers and must only be issued while no beat is in flight.
`timescale 1ns / 1ps

module grade_position_bang_bang (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write port
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [gpbb_pkg::CFG_W-1:0]         cfg_wdata,
    // Input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // tdata: func[1:0], sample[13:2], new_grade[20:14], zero[23:21]
    input  logic [gpbb_pkg::IN_DATA_W-1:0]     s_tdata,
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // tdata: raise_drive[0], lower_drive[1], motion[3:2], settled[4],
    //        target_grade[11:5], status[12], zero[15:13]
    output logic [gpbb_pkg::OUT_DATA_W-1:0]    m_tdata
);

    // Configuration
    logic [gpbb_pkg::STEP_W-1:0]      step_reg;
    logic [gpbb_pkg::GRADE_W-1:0]     max_reg;

    // Controller state
    logic [gpbb_pkg::GRADE_W-1:0]     goal_reg;
    logic [gpbb_pkg::GRADE_W-1:0]     goal_next;
    logic                             settled_reg;
    logic                             settled_next;
    gpbb_pkg::motion_t                mode_reg;
    gpbb_pkg::motion_t                mode_next;

    // Input register
    logic                             in_valid_reg;
    gpbb_pkg::func_t                  in_func_reg;
    logic [gpbb_pkg::SAMPLE_BITS-1:0] in_sample_reg;
    logic [gpbb_pkg::GRADE_W-1:0]     in_grade_reg;

    // Result register
    logic                             out_valid_reg;
    gpbb_pkg::motion_t                out_motion_reg;
    logic                             out_settled_reg;
    logic [gpbb_pkg::GRADE_W-1:0]     out_target_reg;
    logic                             out_status_reg;

    // Datapath
    logic                             out_free;
    logic                             advance;
    logic                             has_req;
    logic [gpbb_pkg::GRADE_W-1:0]     req_grade;
    logic                             req_ok;
    logic                             refused;
    logic                             do_poll;
    logic                             settled_base;
    logic [gpbb_pkg::PROD_W-1:0]      prod;
    logic [gpbb_pkg::PROD_W-1:0]      thr;
    logic [gpbb_pkg::HALF_W-1:0]      half;
    logic [gpbb_pkg::CMP_W-1:0]       now_ext;
    logic [gpbb_pkg::CMP_W-1:0]       thr_ext;
    logic [gpbb_pkg::CMP_W-1:0]       half_ext;

    // Handshake: result register frees when empty or taken
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= gpbb_pkg::STEP_RESET;
            max_reg  <= gpbb_pkg::MAX_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                gpbb_pkg::CFG_GRADE_STEP: step_reg <= cfg_wdata[gpbb_pkg::STEP_W-1:0];
                gpbb_pkg::CFG_MAX_GRADE:  max_reg  <= cfg_wdata[gpbb_pkg::GRADE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register: hold a beat until the result side takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_func_reg   <= gpbb_pkg::func_t'(
                s_tdata[gpbb_pkg::IN_FUNC_LSB +: gpbb_pkg::FUNC_W]);
            in_sample_reg <= s_tdata[gpbb_pkg::IN_SAMPLE_LSB +: gpbb_pkg::SAMPLE_BITS];
            in_grade_reg  <= s_tdata[gpbb_pkg::IN_GRADE_LSB +: gpbb_pkg::GRADE_W];
        end
    end

    // Decode the function into a grade request
    always_comb begin
        has_req   = 1'b0;
        req_grade = goal_reg;
        refused   = 1'b0;
        do_poll   = 1'b0;
        case (in_func_reg)
            gpbb_pkg::FUNC_POLL: begin
                do_poll = 1'b1;
            end
            gpbb_pkg::FUNC_UP: begin
                if (goal_reg < max_reg) begin
                    has_req   = 1'b1;
                    req_grade = goal_reg + gpbb_pkg::GRADE_W'(1);
                end else begin
                    refused = 1'b1;
                end
            end
            gpbb_pkg::FUNC_DOWN: begin
                if (goal_reg > gpbb_pkg::GRADE_W'(1)) begin
                    has_req   = 1'b1;
                    req_grade = goal_reg - gpbb_pkg::GRADE_W'(1);
                end else begin
                    refused = 1'b1;
                end
            end
            gpbb_pkg::FUNC_SET: begin
                has_req   = 1'b1;
                req_grade = in_grade_reg;
            end
            default: begin
            end
        endcase
    end

    // Accept the request only for an in-range, different grade
    assign req_ok = has_req && (req_grade != '0) && (req_grade <= max_reg)
                    && (req_grade != goal_reg);
    assign goal_next    = req_ok ? req_grade : goal_reg;
    assign settled_base = req_ok ? 1'b0 : settled_reg;

    // Threshold: step * goal - step / 2 (never negative since goal >= 1)
    assign half     = step_reg[gpbb_pkg::STEP_W-1:1];
    assign prod     = gpbb_pkg::PROD_W'(step_reg) * gpbb_pkg::PROD_W'(goal_next);
    assign thr      = prod - gpbb_pkg::PROD_W'(half);
    assign now_ext  = gpbb_pkg::CMP_W'(in_sample_reg);
    assign thr_ext  = gpbb_pkg::CMP_W'(thr);
    assign half_ext = gpbb_pkg::CMP_W'(half);

    // Poll or accepted request: start, stop or settle against the threshold
    always_comb begin
        mode_next    = mode_reg;
        settled_next = settled_base;
        if ((do_poll || req_ok) && !settled_base) begin
            case (mode_reg)
                gpbb_pkg::MOTION_NONE: begin
                    if (now_ext + half_ext < thr_ext) begin
                        mode_next = gpbb_pkg::MOTION_UP;
                    end else if (now_ext > thr_ext + half_ext) begin
                        mode_next = gpbb_pkg::MOTION_DOWN;
                    end else begin
                        settled_next = 1'b1;
                    end
                end
                gpbb_pkg::MOTION_UP: begin
                    if (now_ext >= thr_ext) begin
                        mode_next = gpbb_pkg::MOTION_NONE;
                    end
                end
                gpbb_pkg::MOTION_DOWN: begin
                    if (now_ext <= thr_ext) begin
                        mode_next = gpbb_pkg::MOTION_NONE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Advance controller state once per beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            goal_reg    <= gpbb_pkg::GOAL_RESET;
            settled_reg <= 1'b0;
            mode_reg    <= gpbb_pkg::MOTION_NONE;
        end else if (advance) begin
            goal_reg    <= goal_next;
            settled_reg <= settled_next;
            mode_reg    <= mode_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_motion_reg  <= mode_next;
            out_settled_reg <= settled_next;
            out_target_reg  <= goal_next;
            out_status_reg  <= refused;
        end
    end

    // Pack the result beat
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_status_reg,
                       out_target_reg,
                       out_settled_reg,
                       out_motion_reg,
                       (out_motion_reg == gpbb_pkg::MOTION_DOWN),
                       (out_motion_reg == gpbb_pkg::MOTION_UP)};

endmodule

FILE: design/gpbb_checker.sv
// ----------------------------------------------------------------------------
// gpbb_checker
// Port-level checks of the grade position controller's result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gpbb_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [gpbb_pkg::IN_DATA_W-1:0]  s_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [gpbb_pkg::OUT_DATA_W-1:0] m_tdata
);

    logic                         raise_drive;
    logic                         lower_drive;
    logic [1:0]                   motion;
    logic                         settled;
    logic [gpbb_pkg::GRADE_W-1:0] target_grade;
    logic                         in_beat;

    // Unpack the result beat
    assign raise_drive  = m_tdata[0];
    assign lower_drive  = m_tdata[1];
    assign motion       = m_tdata[3:2];
    assign settled      = m_tdata[4];
    assign target_grade = m_tdata[11:5];
    assign in_beat      = s_tvalid && s_tready && (s_tdata[1:0] == gpbb_pkg::FUNC_POLL);

    // Each relay follows its own motion code and never both at once
    `GPBB_ASSERT(a_relay_match, aclk, aresetn, m_tvalid |-> ((raise_drive == (motion == gpbb_pkg::MOTION_UP)) && (lower_drive == (motion == gpbb_pkg::MOTION_DOWN))))

    // A settled result has both relays off
    `GPBB_ASSERT(a_settled_idle, aclk, aresetn, (m_tvalid && settled) |-> (motion == gpbb_pkg::MOTION_NONE))

    // Target grade never drops to zero
    `GPBB_ASSERT(a_grade_nonzero, aclk, aresetn, m_tvalid |-> (target_grade != '0))

    // A stalled result beat holds
    `GPBB_ASSERT(a_stall_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))

    // A poll beat accepted while the result side is empty and ready shows up on the result side
    `GPBB_ASSERT(a_result_follows, aclk, aresetn, (in_beat && m_tready && !m_tvalid) |=> ##1 m_tvalid)

endmodule

bind grade_position_bang_bang gpbb_checker u_gpbb_checker (.*);
